// ----- sv/gwm_pkg.sv -----
// Shared types, codes and helpers for the glob wildcard matcher.
// No dependencies; every other file of the block except gwm_if refers to this package.
`default_nettype none

package gwm_pkg;

    localparam int MAX_PATTERN_DEFAULT = 64;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [7:0] WILD_ANY = 8'h2A;
    localparam logic [7:0] WILD_ONE = 8'h3F;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESTART = 2'd2,
        OP_TEXT    = 2'd3
    } op_t;

    // A request after classification, as it sits in the queue.
    typedef struct packed {
        op_t        op;
        logic [7:0] sym;
        logic       wild_any;
        logic       wild_one;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            return c + CASE_GAP;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gwm_if.sv -----
// Valid/ready channel interfaces for requests into and results out of the matcher.
// Depends on nothing but the field widths of the block.
`default_nettype none

interface gwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] symbol;

    modport source (output valid, output mode, output symbol, input ready);
    modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflow;

    modport source (output valid, output matched, output overflow, input ready);
    modport sink   (input valid, input matched, input overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/gwm_front.sv -----
// Front end: takes requests, folds case and flags wildcards, and pushes them to the queue.
// Depends on gwm_pkg and gwm_if.
`default_nettype none

module gwm_front (
    gwm_in_if.sink              request,
    input  gwm_pkg::q_status_t  q_status,
    output logic                push_valid,
    output gwm_pkg::cmd_t       push_data
);

    assign request.ready = !q_status.full;
    assign push_valid    = request.valid;

    always_comb
    begin
        push_data.op       = gwm_pkg::op_t'(request.mode);
        push_data.sym      = gwm_pkg::fold_case(request.symbol);
        push_data.wild_any = (request.symbol == gwm_pkg::WILD_ANY);
        push_data.wild_one = (request.symbol == gwm_pkg::WILD_ONE);
    end

endmodule

`default_nettype wire

// ----- sv/gwm_queue.sv -----
// Short FIFO of classified requests between the front end and the matching engine.
// Depends on gwm_pkg.
`default_nettype none

module gwm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  gwm_pkg::cmd_t       push_data,
    input  logic                pop_ready,
    output gwm_pkg::cmd_t       pop_data,
    output gwm_pkg::q_status_t  status
);

    localparam int DEPTH = gwm_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    gwm_pkg::cmd_t   entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push_valid && !status.full;
    assign do_pop       = pop_ready && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gwm_back.sv -----
// Matching engine: pattern store, reachable-position vector with star closure, result register.
// Depends on gwm_pkg and gwm_if.
`default_nettype none

module gwm_back #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    input  gwm_pkg::cmd_t  pop_data,
    output logic           pop_ready,
    gwm_out_if.source      result
);

    localparam int N  = MAX_PATTERN + 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [7:0]             ch_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg;
    logic [MAX_PATTERN-1:0] one_reg;
    logic [LW-1:0]          len_reg,    len_next;
    logic                   ovf_reg,    ovf_next;
    logic [N-1:0]           active_reg, active_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   matched_reg,   matched_next;
    logic                   overflow_reg;

    logic                   do_step;
    logic                   append_ok;
    logic [MAX_PATTERN-1:0] star_eff;
    logic [MAX_PATTERN-1:0] in_pat;
    logic [N-1:0]           seed;
    logic [N-1:0]           prop;
    logic [N-1:0]           inj;
    logic [N:0]             sum;

    assign pop_ready = !out_valid_reg || result.ready;
    assign do_step   = pop_valid && pop_ready;
    assign append_ok = (pop_data.op == gwm_pkg::OP_APPEND) && (len_reg != LW'(MAX_PATTERN));

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        unique case (pop_data.op)
            gwm_pkg::OP_CLEAR:
            begin
                len_next = '0;
                ovf_next = 1'b0;
            end
            gwm_pkg::OP_APPEND:
            begin
                if (append_ok)
                begin
                    len_next = len_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Pattern view after this request: the character being appended already counts.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            star_eff[i] = (append_ok && len_reg == LW'(i)) ? pop_data.wild_any : star_reg[i];
            in_pat[i]   = (len_next > LW'(i));
        end
    end

    // One text step before closure; any other request seeds position zero alone.
    always_comb
    begin
        seed = '0;
        if (pop_data.op == gwm_pkg::OP_TEXT)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                if (active_reg[i] && in_pat[i])
                begin
                    if (star_reg[i])
                    begin
                        seed[i] = 1'b1;
                    end
                    else if (one_reg[i] || ch_reg[i] == pop_data.sym)
                    begin
                        seed[i + 1] = 1'b1;
                    end
                end
            end
        end
        else
        begin
            seed[0] = 1'b1;
        end
    end

    // Star closure as a carry chain: a set position injects a carry into the run of
    // star-propagating positions after it, and the add ripples it to the end of the run.
    always_comb
    begin
        prop[0] = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            prop[i + 1] = star_eff[i] && in_pat[i];
        end
        inj          = {seed[N-2:0], 1'b0} & prop;
        sum          = {1'b0, prop} + {1'b0, inj};
        active_next  = seed | inj | ((sum[N-1:0] ^ prop) & prop);
        matched_next = active_next[len_next] && !ovf_next;
    end

    always_comb
    begin
        if (do_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            active_reg    <= N'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_step)
            begin
                len_reg    <= len_next;
                ovf_reg    <= ovf_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            matched_reg  <= matched_next;
            overflow_reg <= ovf_next;
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (do_step && append_ok && len_reg == LW'(i))
            begin
                ch_reg[i]   <= pop_data.sym;
                star_reg[i] <= pop_data.wild_any;
                one_reg[i]  <= pop_data.wild_one;
            end
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.matched  = matched_reg;
    assign result.overflow = overflow_reg;

endmodule

`default_nettype wire

// ----- sv/glob_wildcard_matcher_core.sv -----
// Top level of the glob wildcard matcher: front end, request queue and matching engine.
// Depends on gwm_pkg, gwm_if, gwm_front, gwm_queue and gwm_back.
`default_nettype none

// Case-insensitive whole-string glob matcher. Mode 0 clears the pattern, mode 1 appends
// a pattern character ('*' any run, '?' any one character), mode 2 restarts the text and
// mode 3 feeds one text character; every request yields exactly one result giving the
// match of the text so far against the whole pattern, plus the overflow flag for
// pattern characters dropped beyond MAX_PATTERN. One request is taken every clock
// cycle while results are drained. Each request is written into the two-entry queue when
// it is accepted, and the matching engine registers its result when it takes the entry
// from the queue. A result held back by the consumer stalls the engine, and the queue
// refuses requests once both entries are taken. The critical path is the star closure,
// a carry chain of MAX_PATTERN+1 bits in the matching engine, after the per-position
// character compares.
module glob_wildcard_matcher_core #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    gwm_in_if.sink    request,
    gwm_out_if.source result
);

    logic               push_valid;
    gwm_pkg::cmd_t      push_data;
    gwm_pkg::cmd_t      pop_data;
    logic               pop_ready;
    gwm_pkg::q_status_t q_status;

    gwm_front u_front (
        .request    (request),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    gwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .status     (q_status)
    );

    gwm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (!q_status.empty),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready),
        .result     (result)
    );

    // A dropped pattern character must always suppress a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.matched |-> !result.overflow)
    else $error("match reported while pattern overflow is set");

    // With nothing queued and the result register free, no result can appear next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty && (!result.valid || result.ready) |=> !result.valid)
    else $error("result produced without a queued request");

    // A request is refused whenever the queue holds its full depth, and a full queue never reads as empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_status.empty && !request.ready)
    else $error("queue status inconsistent with request handshake");

endmodule

`default_nettype wire
